// ===== rtl/core/bpa_pkg.sv =====
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types and codes for the buddy page allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bpa_pkg;

  // command codes
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // result status codes
  localparam logic [1:0] STS_OK      = 2'd0;
  localparam logic [1:0] STS_NOSPACE = 2'd1;
  localparam logic [1:0] STS_BADORD  = 2'd2;
  localparam logic [1:0] STS_BADFREE = 2'd3;

  // sequencer states
  typedef enum logic [4:0] {
    ST_INIT,
    ST_IDLE,
    ST_A_SRCH,
    ST_A_SPLRD,
    ST_A_SPL1,
    ST_A_SPL2,
    ST_A_POPRD,
    ST_A_POP,
    ST_F_RD,
    ST_F_CHK,
    ST_M_CHK,
    ST_M_TAG,
    ST_U_CHK,
    ST_U_ADV,
    ST_U_RM,
    ST_M_HI,
    ST_M_PUSH,
    ST_FIN
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/bpa_ram.sv =====
// ----------------------------------------------------------------------------
// bpa_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/buddy_page_allocator_core.sv =====
// ----------------------------------------------------------------------------
// buddy_page_allocator_core
// Buddy page allocator: LIFO free list per order, split on allocate, merge
// with buddy on free, all under one sequencer over three page RAMs.
// ----------------------------------------------------------------------------
// throughput: one beat at a time; the next beat is taken the cycle after the
//   result is loaded, and a stalled result holds the sequencer in its last step
// reset: a clearing pass over every page builds the page tags and free
//   lists before the first input beat is taken
`timescale 1ns / 1ps
`default_nettype none

module buddy_page_allocator_core #(
  parameter int PAGE_COUNT  = 1024,
  parameter int ORDER_COUNT = 11
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_command,
  input  wire logic [3:0]                    in_order,
  input  wire logic [$clog2(PAGE_COUNT)-1:0] in_block_index,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [$clog2(PAGE_COUNT)-1:0] out_page_index,
  output logic      [1:0]                    out_status
);

  import bpa_pkg::*;

  localparam int AW = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int PW = $clog2(PAGE_COUNT + 1);
  localparam int OW = $clog2(ORDER_COUNT + 1);
  localparam int HW = $clog2(ORDER_COUNT);
  localparam int TW = $clog2(ORDER_COUNT + 2);

  localparam logic [PW-1:0] NIL       = PW'(PAGE_COUNT);
  localparam logic [PW-1:0] LAST_PAGE = PW'(PAGE_COUNT - 1);
  localparam logic [OW-1:0] O_END     = OW'(ORDER_COUNT);
  localparam logic [OW-1:0] O_TOP     = OW'(ORDER_COUNT - 1);
  localparam logic [TW-1:0] TAG_ALLOC = TW'(ORDER_COUNT);
  localparam logic [TW-1:0] TAG_INNER = TW'(ORDER_COUNT + 1);

  state_t state_r, state_nxt;

  logic [PW-1:0] head_r [ORDER_COUNT];
  logic          head_we;
  logic [HW-1:0] head_widx;
  logic [PW-1:0] head_wdata;

  logic [OW-1:0] ord_r, ord_nxt, o_r, o_nxt;
  logic [PW-1:0] page_r, page_nxt, bud_r, bud_nxt, cur_r, cur_nxt;
  logic [PW-1:0] prev_r, prev_nxt, saved_r, saved_nxt;
  logic [PW-1:0] sweep_r, sweep_nxt, start_r, start_nxt;
  logic [PW-1:0] res_page_r, res_page_nxt;
  logic [1:0]    res_sts_r, res_sts_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [AW-1:0] out_page_r, out_page_nxt;
  logic [1:0]    out_sts_r, out_sts_nxt;

  // page RAM ports
  logic [AW-1:0] rd_addr;
  logic          tag_we, aord_we, link_we;
  logic [AW-1:0] tag_waddr, aord_waddr, link_waddr;
  logic [TW-1:0] tag_wdata, tag_rd;
  logic [OW-1:0] aord_wdata, aord_rd;
  logic [PW-1:0] link_wdata, link_rd;

  bpa_ram #(.WIDTH(TW), .DEPTH(PAGE_COUNT)) u_tag (
    .clk(clk), .we(tag_we), .waddr(tag_waddr), .wdata(tag_wdata),
    .raddr(rd_addr), .rdata_r(tag_rd)
  );

  bpa_ram #(.WIDTH(OW), .DEPTH(PAGE_COUNT)) u_aord (
    .clk(clk), .we(aord_we), .waddr(aord_waddr), .wdata(aord_wdata),
    .raddr(rd_addr), .rdata_r(aord_rd)
  );

  bpa_ram #(.WIDTH(PW), .DEPTH(PAGE_COUNT)) u_link (
    .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
    .raddr(rd_addr), .rdata_r(link_rd)
  );

  assign in_stall       = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_page_index = out_page_r;
  assign out_status     = out_sts_r;

  // state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      out_valid_r <= 1'b0;
      sweep_r     <= '0;
      start_r     <= '0;
      for (int i = 0; i < ORDER_COUNT; i++) begin
        head_r[i] <= NIL;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      sweep_r     <= sweep_nxt;
      start_r     <= start_nxt;
      if (head_we) begin
        head_r[head_widx] <= head_wdata;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    ord_r      <= ord_nxt;
    o_r        <= o_nxt;
    page_r     <= page_nxt;
    bud_r      <= bud_nxt;
    cur_r      <= cur_nxt;
    prev_r     <= prev_nxt;
    saved_r    <= saved_nxt;
    res_page_r <= res_page_nxt;
    res_sts_r  <= res_sts_nxt;
    out_page_r <= out_page_nxt;
    out_sts_r  <= out_sts_nxt;
  end

  // sequencer
  always_comb begin
    logic [OW-1:0] o_dn, o_up, fit;
    logic [HW-1:0] hi_o, hi_dn, hi_up;
    logic [PW-1:0] head_o, bud, lo_pg, hi_pg;

    o_dn   = o_r - OW'(1);
    o_up   = o_r + OW'(1);
    hi_o   = o_r[HW-1:0];
    hi_dn  = o_dn[HW-1:0];
    hi_up  = o_up[HW-1:0];
    head_o = head_r[hi_o];
    bud    = page_r ^ (PW'(1) << o_r);
    lo_pg  = (page_r < bud_r) ? page_r : bud_r;
    hi_pg  = (page_r < bud_r) ? bud_r : page_r;

    // largest block that fits at the sweep position
    fit = '0;
    for (int k = 0; k < ORDER_COUNT; k++) begin
      if ((32'(sweep_r) + (32'd1 << k)) <= 32'(PAGE_COUNT)) begin
        fit = OW'(k);
      end
    end

    state_nxt     = state_r;
    ord_nxt       = ord_r;
    o_nxt         = o_r;
    page_nxt      = page_r;
    bud_nxt       = bud_r;
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    saved_nxt     = saved_r;
    sweep_nxt     = sweep_r;
    start_nxt     = start_r;
    res_page_nxt  = res_page_r;
    res_sts_nxt   = res_sts_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_page_nxt  = out_page_r;
    out_sts_nxt   = out_sts_r;

    head_we    = 1'b0;
    head_widx  = hi_o;
    head_wdata = page_r;
    rd_addr    = page_r[AW-1:0];
    tag_we     = 1'b0;
    tag_waddr  = page_r[AW-1:0];
    tag_wdata  = TAG_INNER;
    aord_we    = 1'b0;
    aord_waddr = page_r[AW-1:0];
    aord_wdata = ord_r;
    link_we    = 1'b0;
    link_waddr = page_r[AW-1:0];
    link_wdata = head_o;

    unique case (state_r)
      // clearing pass: cut the pool greedily into the largest blocks
      ST_INIT: begin
        tag_we    = 1'b1;
        tag_waddr = sweep_r[AW-1:0];
        if (sweep_r == start_r) begin
          tag_wdata  = TW'(fit);
          link_we    = 1'b1;
          link_waddr = sweep_r[AW-1:0];
          link_wdata = head_r[fit[HW-1:0]];
          head_we    = 1'b1;
          head_widx  = fit[HW-1:0];
          head_wdata = sweep_r;
          start_nxt  = start_r + (PW'(1) << fit);
        end
        sweep_nxt = sweep_r + PW'(1);
        if (sweep_r == LAST_PAGE) begin
          state_nxt = ST_IDLE;
        end
      end

      // take a beat and screen it
      ST_IDLE: begin
        if (in_valid) begin
          res_page_nxt = '0;
          res_sts_nxt  = STS_OK;
          if (in_command == CMD_ALLOC) begin
            ord_nxt = OW'(in_order);
            o_nxt   = OW'(in_order);
            if (32'(in_order) >= 32'(ORDER_COUNT)) begin
              res_sts_nxt = STS_BADORD;
              state_nxt   = ST_FIN;
            end else begin
              state_nxt = ST_A_SRCH;
            end
          end else begin
            page_nxt = PW'(in_block_index);
            if (32'(in_block_index) >= 32'(PAGE_COUNT)) begin
              res_sts_nxt = STS_BADFREE;
              state_nxt   = ST_FIN;
            end else begin
              state_nxt = ST_F_RD;
            end
          end
        end
      end

      // walk up the orders to the first non-empty list
      ST_A_SRCH: begin
        if (o_r == O_END) begin
          res_sts_nxt = STS_NOSPACE;
          state_nxt   = ST_FIN;
        end else if (head_o != NIL) begin
          state_nxt = (o_r == ord_r) ? ST_A_POPRD : ST_A_SPLRD;
        end else begin
          o_nxt = o_up;
        end
      end

      // split: pop the larger block
      ST_A_SPLRD: begin
        page_nxt  = head_o;
        rd_addr   = head_o[AW-1:0];
        state_nxt = ST_A_SPL1;
      end

      ST_A_SPL1: begin
        head_we    = 1'b1;
        head_wdata = link_rd;
        tag_we     = 1'b1;
        tag_wdata  = TW'(o_dn);
        bud_nxt    = page_r + (PW'(1) << o_dn);
        link_we    = 1'b1;
        link_waddr = bud_nxt[AW-1:0];
        link_wdata = head_r[hi_dn];
        state_nxt  = ST_A_SPL2;
      end

      // push upper half, then lower half on top of it
      ST_A_SPL2: begin
        tag_we     = 1'b1;
        tag_waddr  = bud_r[AW-1:0];
        tag_wdata  = TW'(o_dn);
        link_we    = 1'b1;
        link_wdata = bud_r;
        head_we    = 1'b1;
        head_widx  = hi_dn;
        head_wdata = page_r;
        o_nxt      = o_dn;
        state_nxt  = ST_A_SRCH;
      end

      ST_A_POPRD: begin
        page_nxt  = head_o;
        rd_addr   = head_o[AW-1:0];
        state_nxt = ST_A_POP;
      end

      // hand out the head block
      ST_A_POP: begin
        head_we      = 1'b1;
        head_wdata   = link_rd;
        tag_we       = 1'b1;
        tag_wdata    = TAG_ALLOC;
        aord_we      = 1'b1;
        res_page_nxt = page_r;
        state_nxt    = ST_FIN;
      end

      ST_F_RD: begin
        state_nxt = ST_F_CHK;
      end

      // check the freed page and push it
      ST_F_CHK: begin
        if (tag_rd != TAG_ALLOC) begin
          res_sts_nxt = STS_BADFREE;
          state_nxt   = ST_FIN;
        end else begin
          o_nxt      = (aord_rd > O_TOP) ? O_TOP : aord_rd;
          tag_we     = 1'b1;
          tag_wdata  = TW'(o_nxt);
          link_we    = 1'b1;
          link_wdata = head_r[o_nxt[HW-1:0]];
          saved_nxt  = head_r[o_nxt[HW-1:0]];
          head_we    = 1'b1;
          head_widx  = o_nxt[HW-1:0];
          state_nxt  = ST_M_CHK;
        end
      end

      // look up the buddy
      ST_M_CHK: begin
        if (o_r >= O_TOP || bud >= NIL) begin
          state_nxt = ST_FIN;
        end else begin
          bud_nxt   = bud;
          rd_addr   = bud[AW-1:0];
          state_nxt = ST_M_TAG;
        end
      end

      // buddy free at this order: drop our block from the list head
      ST_M_TAG: begin
        if (tag_rd != TW'(o_r)) begin
          state_nxt = ST_FIN;
        end else begin
          head_we    = 1'b1;
          head_wdata = saved_r;
          cur_nxt    = saved_r;
          prev_nxt   = NIL;
          state_nxt  = ST_U_CHK;
        end
      end

      // walk the list for the buddy
      ST_U_CHK: begin
        rd_addr = cur_r[AW-1:0];
        if (cur_r == NIL) begin
          state_nxt = ST_M_HI;
        end else if (cur_r == bud_r) begin
          state_nxt = ST_U_RM;
        end else begin
          state_nxt = ST_U_ADV;
        end
      end

      ST_U_ADV: begin
        prev_nxt  = cur_r;
        cur_nxt   = link_rd;
        state_nxt = ST_U_CHK;
      end

      // unlink the buddy
      ST_U_RM: begin
        if (prev_r == NIL) begin
          head_we    = 1'b1;
          head_wdata = link_rd;
        end else begin
          link_we    = 1'b1;
          link_waddr = prev_r[AW-1:0];
          link_wdata = link_rd;
        end
        state_nxt = ST_M_HI;
      end

      ST_M_HI: begin
        tag_we    = 1'b1;
        tag_waddr = hi_pg[AW-1:0];
        tag_wdata = TAG_INNER;
        state_nxt = ST_M_PUSH;
      end

      // push the merged block one order up
      ST_M_PUSH: begin
        tag_we     = 1'b1;
        tag_waddr  = lo_pg[AW-1:0];
        tag_wdata  = TW'(o_up);
        link_we    = 1'b1;
        link_waddr = lo_pg[AW-1:0];
        link_wdata = head_r[hi_up];
        saved_nxt  = head_r[hi_up];
        head_we    = 1'b1;
        head_widx  = hi_up;
        head_wdata = lo_pg;
        page_nxt   = lo_pg;
        o_nxt      = o_up;
        state_nxt  = ST_M_CHK;
      end

      // load the result beat once the output register is free
      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_page_nxt  = AW'(res_page_r);
          out_sts_nxt   = res_sts_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== tb/sv/buddy_page_allocator_checker.sv =====
// ----------------------------------------------------------------------------
// buddy_page_allocator_checker
// Watches both channels of the buddy page allocator, keeps its own model of
// the free lists and page tags, and compares every result beat in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module buddy_page_allocator_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic       in_command,
  input  logic [3:0] in_order,
  input  logic [9:0] in_block_index,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [9:0] out_page_index,
  input  logic [1:0] out_status,
  output int         fail_count,
  output int         pending_count
);
  import bpa_pkg::*;

  localparam int PAGES  = 1024;
  localparam int ORDERS = 11;
  localparam logic [3:0] TAG_ALLOC = 4'(ORDERS);
  localparam logic [3:0] TAG_INNER = 4'(ORDERS + 1);
  localparam logic [10:0] NO_PAGE = 11'(PAGES);

  typedef struct packed {
    logic [9:0] head_pg;
    logic [1:0] status;
  } grant_t;

  logic [3:0]  tag_mem [PAGES];
  logic [3:0]  order_mem [PAGES];
  logic [10:0] link_mem [PAGES];
  logic [10:0] head_mem [ORDERS];
  grant_t      grant_q [$];

  assign pending_count = grant_q.size();

  function automatic logic [10:0] pop_free(int ord);
    logic [10:0] pg;
    pg = head_mem[ord];
    head_mem[ord] = link_mem[pg];
    return pg;
  endfunction

  function automatic void push_free(int ord, logic [10:0] pg);
    link_mem[pg] = head_mem[ord];
    head_mem[ord] = pg;
  endfunction

  function automatic void drop_free(int ord, logic [10:0] pg);
    logic [10:0] prev, cur;
    int steps;
    prev = NO_PAGE;
    cur = head_mem[ord];
    steps = 0;
    while (cur != NO_PAGE && cur != pg && steps < PAGES) begin
      prev = cur;
      cur = link_mem[cur];
      steps++;
    end
    if (cur != pg) return;
    if (prev == NO_PAGE) head_mem[ord] = link_mem[cur];
    else link_mem[prev] = link_mem[cur];
  endfunction

  // apply one request beat to the shadow state and return its grant
  function automatic grant_t apply_request(logic cmd, logic [3:0] ord, logic [9:0] blk);
    grant_t g;
    int o;
    logic [10:0] lo, hi, idx, bud;
    g = '0;
    if (cmd == CMD_ALLOC) begin
      if (ord >= ORDERS) begin
        g.status = STS_BADORD;
      end else begin
        o = ord;
        while (o < ORDERS && head_mem[o] == NO_PAGE) o++;
        if (o >= ORDERS) begin
          g.status = STS_NOSPACE;
        end else begin
          while (o > ord) begin
            lo = pop_free(o);
            hi = lo + (11'd1 << (o - 1));
            tag_mem[lo] = 4'(o - 1);
            tag_mem[hi] = 4'(o - 1);
            push_free(o - 1, hi);
            push_free(o - 1, lo);
            o--;
          end
          lo = pop_free(ord);
          tag_mem[lo] = TAG_ALLOC;
          order_mem[lo] = ord;
          g.head_pg = lo[9:0];
          g.status = STS_OK;
        end
      end
    end else begin
      idx = {1'b0, blk};
      if (tag_mem[idx] != TAG_ALLOC) begin
        g.status = STS_BADFREE;
      end else begin
        o = order_mem[idx];
        if (o >= ORDERS) o = ORDERS - 1;
        tag_mem[idx] = 4'(o);
        push_free(o, idx);
        while (o + 1 < ORDERS) begin
          bud = idx ^ (11'd1 << o);
          if (bud >= PAGES || tag_mem[bud] != 4'(o)) break;
          drop_free(o, idx);
          drop_free(o, bud);
          lo = idx < bud ? idx : bud;
          hi = idx < bud ? bud : idx;
          tag_mem[hi] = TAG_INNER;
          tag_mem[lo] = 4'(o + 1);
          push_free(o + 1, lo);
          idx = lo;
          o++;
        end
        g.status = STS_OK;
      end
    end
    return g;
  endfunction

  always @(posedge clk) begin
    grant_t exp_g;
    if (!rst_n) begin
      for (int i = 0; i < PAGES; i++) begin
        tag_mem[i] = TAG_INNER;
        order_mem[i] = '0;
        link_mem[i] = '0;
      end
      for (int i = 0; i < ORDERS; i++) head_mem[i] = NO_PAGE;
      // whole pool is one top-order block, alone on its list
      tag_mem[0] = 4'(ORDERS - 1);
      link_mem[0] = NO_PAGE;
      head_mem[ORDERS - 1] = 11'd0;
      grant_q.delete();
      fail_count = 0;
    end else begin
      // result side first: a same-edge request cannot already have its result
      if (out_valid && !out_stall) begin
        if (grant_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result beat: page %0d status %0d",
                     out_page_index, out_status);
        end else begin
          exp_g = grant_q.pop_front();
          if (out_page_index !== exp_g.head_pg || out_status !== exp_g.status) begin
            fail_count++;
            if (fail_count <= 10)
              $display("result mismatch: expected page %0d status %0d, got page %0d status %0d",
                       exp_g.head_pg, exp_g.status, out_page_index, out_status);
          end
        end
      end
      if (in_valid && !in_stall)
        grant_q.push_back(apply_request(in_command, in_order, in_block_index));
    end
  end
endmodule

// ===== tb/sv/buddy_page_allocator_core_tb.sv =====
// ----------------------------------------------------------------------------
// buddy_page_allocator_core_tb
// Drives allocate and free beats with random gaps and stalls into the buddy
// page allocator, mostly freeing pages it was granted, and reports the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module buddy_page_allocator_core_tb;
  import bpa_pkg::*;

  localparam int RANDOM_ITEMS = 1250;
  localparam int IDLE_LIMIT   = 20000;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic       in_command;
  logic [3:0] in_order;
  logic [9:0] in_block_index;
  logic       out_valid;
  logic       out_stall;
  logic [9:0] out_page_index;
  logic [1:0] out_status;
  int         fail_count;
  int         pending_count;
  int         idle_cycles;
  bit         hold_off;
  bit         drain_done;
  logic [9:0] granted_q [$];

  buddy_page_allocator_core dut (.*);

  buddy_page_allocator_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // short gaps mostly, a long one now and then
  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 80);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  // track granted heads so frees mostly target live blocks
  always @(posedge clk)
    if (rst_n && out_valid && !out_stall && out_status == STS_OK && out_page_index != 0)
      granted_q.push_back(out_page_index);
    else if (rst_n && out_valid && !out_stall && out_status == STS_OK && $urandom_range(0, 1))
      granted_q.push_back(out_page_index);

  // valid stays up after the beat is taken; a gap or a drain lowers it
  task automatic send_beat(logic cmd, logic [3:0] ord, logic [9:0] blk);
    in_valid       <= 1'b1;
    in_command     <= cmd;
    in_order       <= ord;
    in_block_index <= blk;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_random();
    int pick, k, gap;
    logic [9:0] blk;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      send_beat(CMD_ALLOC, 4'($urandom_range(0, 5)), 10'($urandom));
    end else if (pick < 52) begin
      send_beat(CMD_ALLOC, 4'($urandom), 10'($urandom));
    end else if (pick < 92 && granted_q.size() > 0) begin
      k = $urandom_range(0, granted_q.size() - 1);
      blk = granted_q[k];
      granted_q.delete(k);
      send_beat(CMD_FREE, 4'($urandom), blk);
    end else begin
      send_beat(CMD_FREE, 4'($urandom), 10'($urandom));
    end
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  // receiver stall pattern, with one long hold-off stretch on request
  initial begin
    int gap;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (600) @(posedge clk);
        hold_off = 1'b0;
      end
      gap = gap_len();
      if ($urandom_range(0, 3) == 0 && gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  // watchdog on cycles with no accepted beat
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_command = CMD_ALLOC;
    in_order = '0;
    in_block_index = '0;
    hold_off = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: whole pool, splits, merges, every special case
    send_beat(CMD_FREE, 4'd0, 10'd0);
    send_beat(CMD_ALLOC, 4'd10, 10'd0);
    send_beat(CMD_ALLOC, 4'd0, 10'd0);
    send_beat(CMD_FREE, 4'd0, 10'd0);
    send_beat(CMD_ALLOC, 4'd0, 10'h3ff);
    send_beat(CMD_ALLOC, 4'd0, 10'd0);
    send_beat(CMD_ALLOC, 4'd3, 10'd0);
    send_beat(CMD_ALLOC, 4'd11, 10'd0);
    send_beat(CMD_ALLOC, 4'd15, 10'h3ff);
    send_beat(CMD_FREE, 4'd15, 10'd1);
    send_beat(CMD_FREE, 4'd0, 10'd1);
    send_beat(CMD_FREE, 4'd0, 10'd3);
    send_beat(CMD_FREE, 4'd0, 10'h3ff);
    send_beat(CMD_FREE, 4'd0, 10'd0);
    send_beat(CMD_FREE, 4'd0, 10'd8);
    send_beat(CMD_FREE, 4'd0, 10'd2);
    send_beat(CMD_ALLOC, 4'd9, 10'd0);
    send_beat(CMD_ALLOC, 4'd9, 10'd0);
    send_beat(CMD_ALLOC, 4'd0, 10'd0);
    send_beat(CMD_FREE, 4'd0, 10'd512);
    send_beat(CMD_FREE, 4'd0, 10'd0);
    wait_drain();
    granted_q.delete();

    // random traffic with one receiver hold-off and one full drain pause
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 300) hold_off = 1'b1;
      if (i == 700) wait_drain();
      send_random();
    end

    wait_drain();
    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
